// ----- sv/dhfk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types, DH table and fixed-point helpers for the 7-joint kinematics.
// ----------------------------------------------------------------------------
package dhfk_pkg;

    localparam int ANGLE_W  = 18;
    localparam int POS_W    = 19;
    localparam int FRAME_W  = 4;
    localparam int COEF_W   = 32;   // Q30 rotation entries, sine, cosine, lengths
    localparam int WIDE_W   = 34;   // Q30 positions and CORDIC datapath
    localparam int PROD_W   = 64;
    localparam int STEP_W   = 5;
    localparam int NUM_ROWS = 8;
    localparam int NUM_JOINTS = 7;

    localparam logic [STEP_W-1:0]  CORDIC_LAST = 5'd29;
    localparam logic [FRAME_W-1:0] LAST_FRAME  = 4'd8;

    localparam logic signed [WIDE_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [WIDE_W-1:0] PI_HALF_Q30 = 34'sd1686629713;
    localparam logic signed [WIDE_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        ALPHA_ZERO,
        ALPHA_POS,
        ALPHA_NEG
    } alpha_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SWAP,
        ST_PMUL,
        ST_PACC,
        ST_CSTART,
        ST_CWAIT,
        ST_RMUL,
        ST_RACC
    } state_t;

    typedef struct packed {
        logic                        start;
        logic signed [ANGLE_W-1:0]   theta;
    } cordic_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [COEF_W-1:0]    cos_v;
        logic signed [COEF_W-1:0]    sin_v;
    } cordic_rsp_t;

    function automatic logic signed [WIDE_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [WIDE_W-1:0] v;
        case (i)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000008;
            5'd28: v = 34'sh000000004;
            5'd29: v = 34'sh000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COEF_W-1:0] dh_a(input logic [2:0] row);
        logic signed [COEF_W-1:0] v;
        case (row)
            3'd3:    v = 32'sd88583700;
            3'd4:    v = -32'sd88583700;
            3'd6:    v = 32'sd94489281;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COEF_W-1:0] dh_d(input logic [2:0] row);
        logic signed [COEF_W-1:0] v;
        case (row)
            3'd0:    v = 32'sd357556027;
            3'd2:    v = 32'sd339302416;
            3'd4:    v = 32'sd412316860;
            3'd7:    v = 32'sd114890375;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic alpha_t dh_alpha(input logic [2:0] row);
        alpha_t v;
        case (row)
            3'd1, 3'd4:             v = ALPHA_NEG;
            3'd2, 3'd3, 3'd5, 3'd6: v = ALPHA_POS;
            default:                v = ALPHA_ZERO;
        endcase
        return v;
    endfunction

    // Round a Q60 product to Q30, half away from zero.
    function automatic logic signed [WIDE_W-1:0] round_q30(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] r;
        m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        r = (m + 64'd536870912) >> 30;
        return v[PROD_W-1] ? -$signed(r[WIDE_W-1:0]) : $signed(r[WIDE_W-1:0]);
    endfunction

    // Q30 position to Q16 output, half away from zero, saturated.
    function automatic logic signed [POS_W-1:0] pack_pos(input logic signed [WIDE_W-1:0] p);
        logic [WIDE_W-1:0] m;
        logic [WIDE_W-1:0] r;
        logic signed [20:0] v;
        m = p[WIDE_W-1] ? WIDE_W'(-p) : WIDE_W'(p);
        r = (m + 34'd8192) >> 14;
        v = p[WIDE_W-1] ? -$signed({1'b0, r[19:0]}) : $signed({1'b0, r[19:0]});
        if (v > 21'sd262143)
            v = 21'sd262143;
        else if (v < -21'sd262144)
            v = -21'sd262144;
        return v[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/dhfk_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhfk_mul
// Shared 32x32 multiplier with registered product and Q30 rounding.
// ----------------------------------------------------------------------------
module dhfk_mul (
    input  wire logic                                 clk,
    input  wire logic signed [dhfk_pkg::COEF_W-1:0]   op_a,
    input  wire logic signed [dhfk_pkg::COEF_W-1:0]   op_b,
    output logic signed [dhfk_pkg::WIDE_W-1:0]        result
);

    logic signed [dhfk_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign result = dhfk_pkg::round_q30(prod_reg);

endmodule
`default_nettype wire

// ----- sv/dhfk_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhfk_cordic
// Iterative CORDIC rotator: one shift-add step per cycle, 30 steps.
// ----------------------------------------------------------------------------
module dhfk_cordic (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dhfk_pkg::cordic_req_t req,
    output dhfk_pkg::cordic_rsp_t      rsp
);

    localparam int W = dhfk_pkg::WIDE_W;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [dhfk_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          flip_reg, flip_next;
    logic signed [W-1:0]           x_reg, x_next;
    logic signed [W-1:0]           y_reg, y_next;
    logic signed [W-1:0]           z_reg, z_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    always_comb
    begin
        logic signed [W-1:0] z0;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] at;
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        z0 = {req.theta[dhfk_pkg::ANGLE_W-1], req.theta, 15'd0};
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = dhfk_pkg::atan_q30(step_reg);
        if (req.start)
        begin
            // fold the angle into [-pi/2, pi/2], negate the result later
            busy_next = 1'b1;
            step_next = '0;
            x_next    = dhfk_pkg::CORDIC_GAIN;
            y_next    = '0;
            if (z0 > dhfk_pkg::PI_HALF_Q30)
            begin
                z_next    = z0 - dhfk_pkg::PI_Q30;
                flip_next = 1'b1;
            end
            else if (z0 < -dhfk_pkg::PI_HALF_Q30)
            begin
                z_next    = z0 + dhfk_pkg::PI_Q30;
                flip_next = 1'b1;
            end
            else
            begin
                z_next    = z0;
                flip_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == dhfk_pkg::CORDIC_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp.done  = done_reg;
        rsp.cos_v = flip_reg ? -x_reg[dhfk_pkg::COEF_W-1:0] : x_reg[dhfk_pkg::COEF_W-1:0];
        rsp.sin_v = flip_reg ? -y_reg[dhfk_pkg::COEF_W-1:0] : y_reg[dhfk_pkg::COEF_W-1:0];
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("cordic done while still iterating");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !req.start |=> busy_reg || done_reg)
        else $error("cordic stopped without done");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= dhfk_pkg::CORDIC_LAST)
        else $error("cordic step out of range");
`endif

endmodule
`default_nettype wire

// ----- sv/dh_forward_kinematics_7dof_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dh_forward_kinematics_7dof_core
// Seven-joint modified-DH forward kinematics, nine frame origins per word.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | joint_angle_1 .. joint_angle_7
//  out     | out_valid / out_stall | frame_index, pos_x, pos_y, pos_z, last_origin
//
//  Per input word the sequencer loads each origin for output, and per DH row
//  runs a swap step and 6 position products on the single shared multiplier;
//  each joint row adds 12 rotation products and a run of the iterative CORDIC;
//  the sequencer returns to idle before it accepts the next word.
//  in_stall is high from acceptance until the flange origin is loaded.
//  An output stall holds the sequencer at the next origin.
//  Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_7dof_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [dhfk_pkg::ANGLE_W-1:0]    joint_angle_1,
    input  wire logic signed [dhfk_pkg::ANGLE_W-1:0]    joint_angle_2,
    input  wire logic signed [dhfk_pkg::ANGLE_W-1:0]    joint_angle_3,
    input  wire logic signed [dhfk_pkg::ANGLE_W-1:0]    joint_angle_4,
    input  wire logic signed [dhfk_pkg::ANGLE_W-1:0]    joint_angle_5,
    input  wire logic signed [dhfk_pkg::ANGLE_W-1:0]    joint_angle_6,
    input  wire logic signed [dhfk_pkg::ANGLE_W-1:0]    joint_angle_7,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [dhfk_pkg::FRAME_W-1:0]                frame_index,
    output logic signed [dhfk_pkg::POS_W-1:0]           pos_x,
    output logic signed [dhfk_pkg::POS_W-1:0]           pos_y,
    output logic signed [dhfk_pkg::POS_W-1:0]           pos_z,
    output logic                                        last_origin
);

    localparam int CW = dhfk_pkg::COEF_W;
    localparam int WW = dhfk_pkg::WIDE_W;
    localparam logic signed [CW-1:0] ONE_Q30 = 32'sd1073741824;

    dhfk_pkg::state_t               state_reg, state_next;
    logic [dhfk_pkg::FRAME_W-1:0]   frame_reg, frame_next;
    logic [1:0]                     r_reg, r_next;
    logic [1:0]                     k_reg, k_next;

    logic signed [dhfk_pkg::ANGLE_W-1:0] angle_reg [dhfk_pkg::NUM_ROWS];
    logic signed [dhfk_pkg::ANGLE_W-1:0] angle_next [dhfk_pkg::NUM_ROWS];
    logic signed [CW-1:0] col0_reg [3], col0_next [3];
    logic signed [CW-1:0] col1_reg [3], col1_next [3];
    logic signed [CW-1:0] col2_reg [3], col2_next [3];
    logic signed [WW-1:0] pos_reg [3], pos_next [3];
    logic signed [WW-1:0] acc0_reg, acc0_next;
    logic signed [WW-1:0] acc1_reg, acc1_next;

    logic                               out_valid_reg, out_valid_next;
    logic [dhfk_pkg::FRAME_W-1:0]       out_frame_reg, out_frame_next;
    logic signed [dhfk_pkg::POS_W-1:0]  out_x_reg, out_x_next;
    logic signed [dhfk_pkg::POS_W-1:0]  out_y_reg, out_y_next;
    logic signed [dhfk_pkg::POS_W-1:0]  out_z_reg, out_z_next;

    logic signed [CW-1:0]   mul_a;
    logic signed [CW-1:0]   mul_b;
    logic signed [WW-1:0]   mul_res;
    dhfk_pkg::cordic_req_t  creq;
    dhfk_pkg::cordic_rsp_t  crsp;
    logic [2:0]             row;

    assign row = frame_reg[2:0];

    dhfk_mul u_mul (
        .clk    (clk),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .result (mul_res)
    );

    dhfk_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dhfk_pkg::ST_IDLE;
            frame_reg     <= '0;
            r_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            r_reg         <= r_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg     <= angle_next;
        col0_reg      <= col0_next;
        col1_reg      <= col1_next;
        col2_reg      <= col2_next;
        pos_reg       <= pos_next;
        acc0_reg      <= acc0_next;
        acc1_reg      <= acc1_next;
        out_frame_reg <= out_frame_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_z_reg     <= out_z_next;
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == dhfk_pkg::ST_PMUL)
        begin
            if (k_reg == 2'd0)
            begin
                mul_a = dhfk_pkg::dh_a(row);
                mul_b = col0_reg[r_reg];
            end
            else
            begin
                mul_a = dhfk_pkg::dh_d(row);
                mul_b = col2_reg[r_reg];
            end
        end
        else if (state_reg == dhfk_pkg::ST_RMUL)
        begin
            unique case (k_reg)
                2'd0:
                begin
                    mul_a = crsp.cos_v;
                    mul_b = col0_reg[r_reg];
                end
                2'd1:
                begin
                    mul_a = crsp.sin_v;
                    mul_b = col1_reg[r_reg];
                end
                2'd2:
                begin
                    mul_a = crsp.cos_v;
                    mul_b = col1_reg[r_reg];
                end
                2'd3:
                begin
                    mul_a = crsp.sin_v;
                    mul_b = col0_reg[r_reg];
                end
            endcase
        end
    end

    always_comb
    begin
        logic load;
        logic signed [WW-1:0] rot_sum;
        state_next     = state_reg;
        frame_next     = frame_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        angle_next     = angle_reg;
        col0_next      = col0_reg;
        col1_next      = col1_reg;
        col2_next      = col2_reg;
        pos_next       = pos_reg;
        acc0_next      = acc0_reg;
        acc1_next      = acc1_reg;
        out_frame_next = out_frame_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_valid_next = out_valid_reg && out_stall;
        creq.start     = 1'b0;
        creq.theta     = angle_reg[row];
        in_stall       = (state_reg != dhfk_pkg::ST_IDLE);
        load           = !out_valid_reg || !out_stall;
        rot_sum        = '0;

        unique case (state_reg)
            dhfk_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    angle_next[0] = joint_angle_1;
                    angle_next[1] = joint_angle_2;
                    angle_next[2] = joint_angle_3;
                    angle_next[3] = joint_angle_4;
                    angle_next[4] = joint_angle_5;
                    angle_next[5] = joint_angle_6;
                    angle_next[6] = joint_angle_7;
                    angle_next[7] = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        col0_next[i] = (i == 0) ? ONE_Q30 : '0;
                        col1_next[i] = (i == 1) ? ONE_Q30 : '0;
                        col2_next[i] = (i == 2) ? ONE_Q30 : '0;
                        pos_next[i]  = '0;
                    end
                    frame_next = '0;
                    state_next = dhfk_pkg::ST_EMIT;
                end
            end
            dhfk_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = frame_reg;
                    out_x_next     = dhfk_pkg::pack_pos(pos_reg[0]);
                    out_y_next     = dhfk_pkg::pack_pos(pos_reg[1]);
                    out_z_next     = dhfk_pkg::pack_pos(pos_reg[2]);
                    state_next     = (frame_reg == dhfk_pkg::LAST_FRAME) ?
                                     dhfk_pkg::ST_IDLE : dhfk_pkg::ST_SWAP;
                end
            end
            dhfk_pkg::ST_SWAP:
            begin
                // alpha of +-pi/2 swaps columns 1 and 2 with a sign
                for (int i = 0; i < 3; i++)
                begin
                    unique case (dhfk_pkg::dh_alpha(row))
                        dhfk_pkg::ALPHA_POS:
                        begin
                            col1_next[i] = col2_reg[i];
                            col2_next[i] = -col1_reg[i];
                        end
                        dhfk_pkg::ALPHA_NEG:
                        begin
                            col1_next[i] = -col2_reg[i];
                            col2_next[i] = col1_reg[i];
                        end
                        default:
                        begin
                            col1_next[i] = col1_reg[i];
                            col2_next[i] = col2_reg[i];
                        end
                    endcase
                end
                r_next     = '0;
                k_next     = '0;
                state_next = dhfk_pkg::ST_PMUL;
            end
            dhfk_pkg::ST_PMUL:
            begin
                state_next = dhfk_pkg::ST_PACC;
            end
            dhfk_pkg::ST_PACC:
            begin
                pos_next[r_reg] = pos_reg[r_reg] + mul_res;
                if (k_reg == 2'd0)
                begin
                    k_next     = 2'd1;
                    state_next = dhfk_pkg::ST_PMUL;
                end
                else
                begin
                    k_next = '0;
                    if (r_reg == 2'd2)
                    begin
                        r_next = '0;
                        if (row == 3'd7)
                        begin
                            // flange: skip the rotation
                            frame_next = frame_reg + 1'b1;
                            state_next = dhfk_pkg::ST_EMIT;
                        end
                        else
                            state_next = dhfk_pkg::ST_CSTART;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = dhfk_pkg::ST_PMUL;
                    end
                end
            end
            dhfk_pkg::ST_CSTART:
            begin
                creq.start = 1'b1;
                state_next = dhfk_pkg::ST_CWAIT;
            end
            dhfk_pkg::ST_CWAIT:
            begin
                if (crsp.done)
                begin
                    r_next     = '0;
                    k_next     = '0;
                    state_next = dhfk_pkg::ST_RMUL;
                end
            end
            dhfk_pkg::ST_RMUL:
            begin
                state_next = dhfk_pkg::ST_RACC;
            end
            dhfk_pkg::ST_RACC:
            begin
                k_next     = k_reg + 1'b1;
                state_next = dhfk_pkg::ST_RMUL;
                unique case (k_reg)
                    2'd0: acc0_next = mul_res;
                    2'd1: acc0_next = acc0_reg + mul_res;
                    2'd2: acc1_next = mul_res;
                    2'd3:
                    begin
                        // hold old column entries until all four products are in
                        rot_sum          = acc1_reg - mul_res;
                        col0_next[r_reg] = acc0_reg[CW-1:0];
                        col1_next[r_reg] = rot_sum[CW-1:0];
                        if (r_reg == 2'd2)
                        begin
                            r_next     = '0;
                            frame_next = frame_reg + 1'b1;
                            state_next = dhfk_pkg::ST_EMIT;
                        end
                        else
                            r_next = r_reg + 1'b1;
                    end
                endcase
            end
            default:
            begin
                state_next = dhfk_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign frame_index = out_frame_reg;
    assign pos_x       = out_x_reg;
    assign pos_y       = out_y_reg;
    assign pos_z       = out_z_reg;
    assign last_origin = (out_frame_reg == dhfk_pkg::LAST_FRAME);

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg <= dhfk_pkg::LAST_FRAME)
        else $error("frame counter past flange");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_frame_reg == 4'd0 |->
        out_x_reg == '0 && out_y_reg == '0 && out_z_reg == '0)
        else $error("base origin not zero");
    assert property (@(posedge clk) disable iff (!rst_n)
        crsp.done |-> state_reg == dhfk_pkg::ST_CWAIT)
        else $error("cordic result outside wait state");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dhfk_pkg::ST_EMIT && frame_reg == dhfk_pkg::LAST_FRAME &&
        (!out_valid_reg || !out_stall) |=> state_reg == dhfk_pkg::ST_IDLE && last_origin)
        else $error("flange origin did not end the run");
`endif

endmodule
`default_nettype wire
